FILE: design/dshot_pkg.sv
// Shared types, constants and frame builder for the DShot frame transmitter.
`default_nettype none
package dshot_pkg;

  localparam int unsigned TickBits   = 10;
  localparam int unsigned PeriodBits = TickBits + 1;
  localparam int unsigned CfgBits    = 10;
  localparam int unsigned TrailBits  = 3;
  localparam int unsigned SlotBits   = 5;
  localparam int unsigned FrameBits  = 16;
  localparam int unsigned CmpBits    = 17;
  localparam int unsigned AddrBits   = 4;
  localparam int unsigned DataBits   = 32;
  localparam int unsigned ThrottleMax = 2047;

  localparam logic [CfgBits-1:0]   BitPeriodReset = CfgBits'(40);
  localparam logic [CfgBits-1:0]   OneHighReset   = CfgBits'(30);
  localparam logic [CfgBits-1:0]   ZeroHighReset  = CfgBits'(15);
  localparam logic [TrailBits-1:0] TrailReset     = TrailBits'(2);

  typedef enum logic [1:0] {
    RegBitPeriod = 2'd0,
    RegOneHigh   = 2'd1,
    RegZeroHigh  = 2'd2,
    RegTrailing  = 2'd3
  } reg_idx_e;

  typedef enum logic {
    ActTick = 1'b0,
    ActLoad = 1'b1
  } action_e;

  typedef struct packed {
    logic        action;
    logic [15:0] throttle;
    logic        telemetry;
  } in_word_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic load_accepted;
  } out_word_t;

  typedef struct packed {
    logic                 is_load;
    logic [FrameBits-1:0] frame;
  } cmd_t;

  typedef struct packed {
    logic [CfgBits-1:0]   bit_period;
    logic [CfgBits-1:0]   one_high;
    logic [CfgBits-1:0]   zero_high;
    logic [TrailBits-1:0] trailing;
  } cfg_t;

  function automatic logic [FrameBits-1:0] build_frame(logic [15:0] thr, logic tel);
    logic [10:0] sat;
    logic [11:0] word;
    logic [3:0]  csum;
    sat  = (thr > 16'(ThrottleMax)) ? 11'(ThrottleMax) : thr[10:0];
    word = {sat, tel};
    csum = word[3:0] ^ word[7:4] ^ word[11:8];
    return {word, csum};
  endfunction

endpackage
`default_nettype wire

FILE: design/dshot_front.sv
// Front end: takes input words, classifies them and builds frames for the queue.
`default_nettype none
module dshot_front import dshot_pkg::*; (
  input  wire logic     in_valid_i,
  input  wire in_word_t in_word_i,
  output logic          in_stall_o,
  input  wire logic     q_full_i,
  output logic          q_push_o,
  output cmd_t          q_cmd_o
);

  assign in_stall_o      = q_full_i;
  assign q_push_o        = in_valid_i & ~q_full_i;
  assign q_cmd_o.is_load = (in_word_i.action == ActLoad);
  assign q_cmd_o.frame   = build_frame(in_word_i.throttle, in_word_i.telemetry);

endmodule
`default_nettype wire

FILE: design/dshot_queue.sv
// Two-entry command queue between the front end and the waveform engine.
`default_nettype none
module dshot_queue import dshot_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t wdata_i,
  output logic      full_o,
  output logic      valid_o,
  output cmd_t      rdata_o,
  input  wire logic pop_i
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2) else $error("queue count out of range");

  a_pointer_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

FILE: design/dshot_back.sv
// Waveform engine: runs queued commands and holds the result word register.
`default_nettype none
module dshot_back import dshot_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic q_valid_i,
  input  wire cmd_t q_cmd_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  output out_word_t out_word_o,
  input  wire logic out_stall_i
);

  logic [FrameBits-1:0]  shift_q, shift_d;
  logic [SlotBits-1:0]   slot_q, slot_d;
  logic [TickBits-1:0]   tick_q, tick_d;
  logic                  sending_q, sending_d;
  logic                  out_valid_q;
  out_word_t             out_q, res;

  logic                  take;
  logic [CmpBits-1:0]    bp_w, cap_w, per_w, high_w;
  logic [PeriodBits-1:0] period, tick_inc;
  logic [SlotBits-1:0]   slot_inc, slot_end;

  assign q_pop_o     = q_valid_i & (~out_valid_q | ~out_stall_i);
  assign take        = q_pop_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    bp_w   = CmpBits'(cfg_i.bit_period);
    cap_w  = CmpBits'(1) << TickBits;
    per_w  = (bp_w > cap_w) ? cap_w : bp_w;
    if (per_w == '0) begin
      per_w = CmpBits'(1);
    end
    period   = per_w[PeriodBits-1:0];
    high_w   = shift_q[FrameBits-1] ? CmpBits'(cfg_i.one_high) : CmpBits'(cfg_i.zero_high);
    tick_inc = PeriodBits'(tick_q) + PeriodBits'(1);
    slot_inc = slot_q + SlotBits'(1);
    slot_end = SlotBits'(FrameBits) + SlotBits'(cfg_i.trailing);

    shift_d   = shift_q;
    slot_d    = slot_q;
    tick_d    = tick_q;
    sending_d = sending_q;
    res       = '0;

    if (q_cmd_i.is_load) begin
      if (!sending_q) begin
        shift_d           = q_cmd_i.frame;
        slot_d            = '0;
        tick_d            = '0;
        sending_d         = 1'b1;
        res.load_accepted = 1'b1;
      end
      res.busy_res = 1'b1;
    end else if (sending_q) begin
      res.busy_res = 1'b1;
      if (slot_q < SlotBits'(FrameBits)) begin
        res.line_level = (CmpBits'(tick_q) < high_w);
      end
      if (tick_inc >= period) begin
        tick_d  = '0;
        shift_d = {shift_q[FrameBits-2:0], 1'b0};
        slot_d  = slot_inc;
        if (slot_inc >= slot_end) begin
          sending_d      = 1'b0;
          slot_d         = '0;
          res.frame_done = 1'b1;
        end
      end else begin
        tick_d = tick_inc[TickBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= '0;
      slot_q      <= '0;
      tick_q      <= '0;
      sending_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        shift_q   <= shift_d;
        slot_q    <= slot_d;
        tick_q    <= tick_d;
        sending_q <= sending_d;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= res;
    end
  end

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SlotBits'(FrameBits + 7)) else $error("slot index out of range");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.frame_done) |-> (out_q.busy_res && !sending_q))
    else $error("frame end flagged without busy or with sending still set");

  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.load_accepted) |-> (out_q.busy_res && !out_q.line_level))
    else $error("accepted load shows line activity");

  a_idle_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sending_q |-> (slot_q == '0)) else $error("idle engine holds a slot index");

endmodule
`default_nettype wire

FILE: design/dshot_frame_transmitter.sv
// Top level of the DShot frame transmitter: register port, front end, queue and engine.
//
//   channel  direction  handshake                      word
//   in       input      in_valid_i / in_stall_o        in_word_t  {action, throttle, telemetry}
//   out      output     out_valid_o / out_stall_i      out_word_t {line_level, busy_res,
//                                                                 frame_done, load_accepted}
//   cfg      input      psel / penable / pwrite        four registers at 0x0, 0x4, 0x8, 0xC
//
// One word is accepted and one result delivered per clock when neither side stalls.
// A word is first written into the two-entry queue and then taken from the queue into the
// engine's result register, from which its result is presented.
// Reset is asynchronous and active low; it empties the queue, idles the engine and
// restores the register defaults. No clearing pass follows reset.
// A stalled output holds its result; the queue then fills and stalls the input.
`default_nettype none
module dshot_frame_transmitter import dshot_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire in_word_t            in_word_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  output out_word_t                out_word_o,
  input  wire logic                out_stall_i,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [AddrBits-1:0] paddr,
  input  wire logic [DataBits-1:0] pwdata,
  output logic      [DataBits-1:0] prdata,
  output logic                     pready
);

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     wr_en;
  logic     q_full, q_push, q_valid, q_pop;
  cmd_t     q_wcmd, q_rcmd;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_period <= BitPeriodReset;
      cfg_q.one_high   <= OneHighReset;
      cfg_q.zero_high  <= ZeroHighReset;
      cfg_q.trailing   <= TrailReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegBitPeriod: cfg_q.bit_period <= pwdata[CfgBits-1:0];
        RegOneHigh:   cfg_q.one_high   <= pwdata[CfgBits-1:0];
        RegZeroHigh:  cfg_q.zero_high  <= pwdata[CfgBits-1:0];
        RegTrailing:  cfg_q.trailing   <= pwdata[TrailBits-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegBitPeriod: prdata = DataBits'(cfg_q.bit_period);
      RegOneHigh:   prdata = DataBits'(cfg_q.one_high);
      RegZeroHigh:  prdata = DataBits'(cfg_q.zero_high);
      RegTrailing:  prdata = DataBits'(cfg_q.trailing);
      default:      prdata = '0;
    endcase
  end

  dshot_front u_front (
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_wcmd)
  );

  dshot_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wcmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .rdata_o (q_rcmd),
    .pop_i   (q_pop)
  );

  dshot_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_rcmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .out_stall_i (out_stall_i)
  );

endmodule
`default_nettype wire

FILE: test/tb_dshot_frame_transmitter.sv
// Self-checking testbench for the DShot frame transmitter: directed frames, extremes and random traffic.
module tb_dshot_frame_transmitter;
  timeunit 1ns;
  timeprecision 1ps;

  import dshot_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned WholeFrame = 32'hffff_ffff;
  localparam int unsigned RandomWords = 900;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  in_word_t            in_word = '0;
  logic                in_stall;
  logic                out_valid;
  out_word_t           out_word;
  logic                out_stall = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrBits-1:0] paddr = '0;
  logic [DataBits-1:0] pwdata = '0;
  logic [DataBits-1:0] prdata;
  logic                pready;

  cfg_t cfg_now = '{bit_period: BitPeriodReset, one_high: OneHighReset,
                    zero_high: ZeroHighReset, trailing: TrailReset};
  logic [FrameBits-1:0] tx_shift = '0;
  logic [SlotBits-1:0]  tx_slot = '0;
  int unsigned          tx_tick = 0;
  bit                   tx_active = 1'b0;

  out_word_t   expected_words[$];
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned words_sent = 0;
  bit          steady = 1'b0;

  dshot_frame_transmitter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_word_i   (in_word),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_word_o  (out_word),
    .out_stall_i (out_stall),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  function automatic logic [FrameBits-1:0] dshot_frame(logic [15:0] thr, logic tel);
    logic [10:0] level_thr;
    logic [11:0] body;
    level_thr = (thr > 16'(ThrottleMax)) ? 11'(ThrottleMax) : thr[10:0];
    body = {level_thr, tel};
    return {body, body[11:8] ^ body[7:4] ^ body[3:0]};
  endfunction

  function automatic out_word_t advance_line(in_word_t w);
    out_word_t   r;
    int unsigned period;
    int unsigned high;
    r = '0;
    if (w.action == ActLoad) begin
      if (!tx_active) begin
        tx_shift = dshot_frame(w.throttle, w.telemetry);
        tx_slot = '0;
        tx_tick = 0;
        tx_active = 1'b1;
        r.load_accepted = 1'b1;
      end
      r.busy_res = tx_active;
    end else if (tx_active) begin
      period = (cfg_now.bit_period == '0) ? 1 : int'(cfg_now.bit_period);
      r.busy_res = 1'b1;
      if (tx_slot < FrameBits) begin
        high = tx_shift[FrameBits-1] ? int'(cfg_now.one_high) : int'(cfg_now.zero_high);
        r.line_level = (tx_tick < high);
      end
      tx_tick++;
      if (tx_tick >= period) begin
        tx_tick = 0;
        tx_shift = tx_shift << 1;
        tx_slot++;
        if (int'(tx_slot) >= FrameBits + int'(cfg_now.trailing)) begin
          tx_active = 1'b0;
          tx_slot = '0;
          r.frame_done = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [DataBits-1:0] register_value(reg_idx_e idx);
    case (idx)
      RegBitPeriod: return DataBits'(cfg_now.bit_period);
      RegOneHigh:   return DataBits'(cfg_now.one_high);
      RegZeroHigh:  return DataBits'(cfg_now.zero_high);
      default:      return DataBits'(cfg_now.trailing);
    endcase
  endfunction

  function automatic logic [15:0] rand_throttle();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'($urandom_range(0, ThrottleMax));
      2:       return 16'($urandom_range(ThrottleMax - 8, ThrottleMax + 8));
      default: return ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
    endcase
  endfunction

  task automatic send_word(input logic act, input logic [15:0] thr, input logic tel);
    in_word_t    w;
    int unsigned gap;
    w.action = act;
    w.throttle = thr;
    w.telemetry = tel;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    expected_words.push_back(advance_line(w));
    words_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input reg_idx_e idx, input logic [DataBits-1:0] data,
                            output logic [DataBits-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    if (wr) begin
      case (idx)
        RegBitPeriod: cfg_now.bit_period = data[CfgBits-1:0];
        RegOneHigh:   cfg_now.one_high = data[CfgBits-1:0];
        RegZeroHigh:  cfg_now.zero_high = data[CfgBits-1:0];
        default:      cfg_now.trailing = data[TrailBits-1:0];
      endcase
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_register(input reg_idx_e idx, input logic [DataBits-1:0] value);
    logic [DataBits-1:0] rd;
    apb_access(1'b1, idx, value, rd);
    apb_access(1'b0, idx, '0, rd);
    if (rd !== register_value(idx))
      note_failure($sformatf("register %0d read back: expected %0d got %0d",
                             idx, register_value(idx), rd));
  endtask

  task automatic configure(input int unsigned period, input int unsigned one,
                           input int unsigned zero, input int unsigned trail);
    drain_results();
    set_register(RegBitPeriod, period);
    set_register(RegOneHigh, one);
    set_register(RegZeroHigh, zero);
    set_register(RegTrailing, trail);
  endtask

  task automatic run_frame(input logic [15:0] thr, input logic tel, input int unsigned noise_pct,
                           input int unsigned max_ticks);
    int unsigned ticks;
    ticks = 0;
    send_word(ActLoad, thr, tel);
    while (tx_active && ticks < max_ticks) begin
      if ($urandom_range(1, 100) <= noise_pct) begin
        send_word(ActLoad, rand_throttle(), 1'($urandom_range(0, 1)));
      end else begin
        send_word(ActTick, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        ticks++;
      end
    end
  endtask

  task automatic test_register_defaults();
    logic [DataBits-1:0] rd;
    for (int i = 0; i < 4; i++) begin
      apb_access(1'b0, reg_idx_e'(i), '0, rd);
      if (rd !== register_value(reg_idx_e'(i)))
        note_failure($sformatf("register %0d after reset: expected %0d got %0d",
                               i, register_value(reg_idx_e'(i)), rd));
    end
    run_frame(16'd1046, 1'b0, 0, 120);
  endtask

  task automatic test_refused_load_and_short_slots();
    configure(0, 1, 0, 0);
    send_word(ActTick, 16'h0000, 1'b0);
    send_word(ActLoad, 16'hffff, 1'b1);
    send_word(ActLoad, 16'h0005, 1'b0);
    while (tx_active) send_word(ActTick, 16'hffff, 1'b1);
    send_word(ActTick, 16'h5a5a, 1'b1);
  endtask

  task automatic test_extreme_settings();
    configure(1, 0, 1, 7);
    run_frame(16'd2048, 1'b1, 0, WholeFrame);
    configure(1023, 1023, 0, 7);
    run_frame(16'd0, 1'b0, 0, 40);
    configure(2, 1023, 0, 0);
    run_frame(16'd2047, 1'b1, 0, WholeFrame);
  endtask

  task automatic test_random_frames();
    int unsigned first;
    int unsigned period;
    int unsigned limit;
    first = words_sent;
    while (words_sent - first < RandomWords) begin
      period = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
      configure(period, $urandom_range(0, period + 2), $urandom_range(0, period + 2),
                $urandom_range(0, 7));
      steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) begin
        if (words_sent - first < RandomWords) begin
          repeat ($urandom_range(0, 2))
            send_word(ActTick, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
          limit = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : WholeFrame;
          if (words_sent - first >= RandomWords) begin
            limit = 0;
          end else if (limit > RandomWords - (words_sent - first)) begin
            limit = RandomWords - (words_sent - first);
          end
          run_frame(rand_throttle(), 1'($urandom_range(0, 1)), 8, limit);
        end
      end
    end
    steady = 1'b0;
  endtask

  task automatic test_drain_pause();
    configure(3, 2, 1, 1);
    run_frame(rand_throttle(), 1'b1, 5, 10);
    drain_results();
    run_frame(rand_throttle(), 1'b0, 5, 10);
    drain_results();
    run_frame(rand_throttle(), 1'b1, 5, WholeFrame);
  endtask

  initial begin : result_checker
    out_word_t   exp;
    int unsigned hold;
    forever begin
      hold = steady ? 0 : $urandom_range(0, 5);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall <= 1'b0;
      end
      do @(posedge clk_i); while (out_valid !== 1'b1);
      if (expected_words.size() == 0) begin
        note_failure($sformatf("result word %b with nothing expected", out_word));
      end else begin
        exp = expected_words.pop_front();
        if (out_word.line_level !== exp.line_level || out_word.busy_res !== exp.busy_res ||
            out_word.frame_done !== exp.frame_done ||
            out_word.load_accepted !== exp.load_accepted)
          note_failure($sformatf("result word {level,busy,done,accepted}: expected %b got %b",
                                 exp, out_word));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_defaults();
    test_refused_load_and_short_slots();
    test_extreme_settings();
    test_random_frames();
    test_drain_pause();
    drain_results();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/dshot_pkg.sv
design/dshot_front.sv
design/dshot_queue.sv
design/dshot_back.sv
design/dshot_frame_transmitter.sv
test/tb_dshot_frame_transmitter.sv
